[hw/rtl/thf_pkg.sv]
package thf_pkg;

   localparam int TempWidth  = 16;
   localparam int SwingWidth = 15;
   localparam int TimeWidth  = 32;
   localparam int DelayWidth = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   // Limits are computed one bit wider than target plus swing can reach.
   localparam int LimitWidth = TempWidth + 2;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_HEAT = 2'd1;
   localparam logic [1:0] MODE_COOL = 2'd2;

   localparam logic [CsrIdxWidth-1:0] REG_MODE_REQUEST = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_TARGET_TEMP  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_SWING        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_FORCE_FAN    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_MIN_TEMP     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_FAN_DELAY_MS = 3'd5;

   localparam logic [DelayWidth-1:0] FAN_DELAY_RESET = 16'd30000;

   typedef struct packed {
      logic            drive_enable;
      logic            select_cool;
      logic            fan_on;
      logic            fan_forced_ind;
      logic            fan_auto_ind;
      logic            heat_req_ind;
      logic            cool_req_ind;
      logic            led_off;
      logic [1:0]      active_mode;
      logic            report_changed;
   } result_type;

endpackage

[hw/rtl/thermostat_hysteresis_fan_controller.sv]
// Thermostat with hysteresis and a delayed fan.
// Input channel (req_): one beat carries a signed temperature sample and a
// wrapping millisecond timestamp. Result channel (rsp_): one beat per input
// beat with the equipment enable, heat/cool select, fan drive, indicator bits,
// the active mode and a change pulse for status publishing.
// Configuration (csr_): index and data, always ready; write only while idle.
// Indexes: 0 mode request, 1 target, 2 swing, 3 force fan, 4 min temp,
// 5 fan delay in ms. Other indexes are ignored.
// An accepted beat is registered in the input stage, and its result is
// loaded into the output register once that register is empty or being
// taken. Throughput is one beat per cycle while the receiver does not stall;
// the single decision stage updates mode, fan and delay state as each beat
// moves from the input register into the output register.
// When the receiver stalls, the output register holds its beat and the input
// stage holds one more; req_stall rises only once both are full.
// Reset clears both stages, the state (mode off, fan off, delay end zero) and
// the registers (all zero, fan delay 30000 ms).
module thermostat_hysteresis_fan_controller
   import thf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [TempWidth-1:0]   req_temperature,
   input  logic        [TimeWidth-1:0]   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drive_enable,
   output logic                          rsp_select_cool,
   output logic                          rsp_fan_on,
   output logic                          rsp_fan_forced_ind,
   output logic                          rsp_fan_auto_ind,
   output logic                          rsp_heat_req_ind,
   output logic                          rsp_cool_req_ind,
   output logic                          rsp_led_off,
   output logic [1:0]                    rsp_active_mode,
   output logic                          rsp_report_changed,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CsrDataWidth-1:0]       csr_data
);

   // Configuration registers.
   logic [1:0]                  mode_request_ff;
   logic signed [TempWidth-1:0] target_temp_ff;
   logic [SwingWidth-1:0]       swing_ff;
   logic                        force_fan_ff;
   logic signed [TempWidth-1:0] min_temp_ff;
   logic [DelayWidth-1:0]       fan_delay_ms_ff;

   // Controller state.
   logic [1:0]           output_mode_ff, output_mode_in;
   logic                 fan_running_ff, fan_running_in;
   logic [TimeWidth-1:0] fan_delay_end_ff, fan_delay_end_in;

   // Input stage.
   logic                        in_valid_ff;
   logic signed [TempWidth-1:0] in_temp_ff;
   logic [TimeWidth-1:0]        in_now_ff;

   // Output stage.
   logic       out_valid_ff;
   result_type out_ff, out_in;

   logic advance;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_request_ff <= MODE_OFF;
         target_temp_ff  <= '0;
         swing_ff        <= '0;
         force_fan_ff    <= 1'b0;
         min_temp_ff     <= '0;
         fan_delay_ms_ff <= FAN_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE_REQUEST: mode_request_ff <= csr_data[1:0];
            REG_TARGET_TEMP:  target_temp_ff  <= csr_data;
            REG_SWING:        swing_ff        <= csr_data[SwingWidth-1:0];
            REG_FORCE_FAN:    force_fan_ff    <= csr_data[0];
            REG_MIN_TEMP:     min_temp_ff     <= csr_data;
            REG_FAN_DELAY_MS: fan_delay_ms_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Mode decision, fan delay and fan table for the beat in the input stage.
   always_comb begin
      logic signed [LimitWidth-1:0] temp_x;
      logic signed [LimitWidth-1:0] lo;
      logic signed [LimitWidth-1:0] hi;
      logic                         below_lo;
      logic                         below_hi;
      logic                         en;
      logic                         sel;
      logic                         equip_on;
      logic                         delay_done;
      logic [TimeWidth-1:0]         since_end;

      temp_x   = LimitWidth'(in_temp_ff);
      lo       = LimitWidth'(target_temp_ff) - $signed({3'b000, swing_ff});
      hi       = LimitWidth'(target_temp_ff) + $signed({3'b000, swing_ff});
      below_lo = temp_x < lo;
      below_hi = temp_x < hi;
      en       = 1'b0;
      sel      = 1'b0;
      output_mode_in = output_mode_ff;

      if (in_temp_ff < min_temp_ff) begin
         output_mode_in = MODE_HEAT;
         en = 1'b1;
      end else begin
         case (mode_request_ff)
            MODE_HEAT: begin
               if (below_lo || (below_hi && output_mode_ff == MODE_HEAT)) begin
                  output_mode_in = MODE_HEAT;
                  en = 1'b1;
               end else begin
                  output_mode_in = MODE_OFF;
               end
            end
            MODE_COOL: begin
               if (!below_hi || (!below_lo && output_mode_ff == MODE_COOL)) begin
                  output_mode_in = MODE_COOL;
                  en  = 1'b1;
                  sel = 1'b1;
               end else begin
                  output_mode_in = MODE_OFF;
               end
            end
            MODE_OFF: output_mode_in = MODE_OFF;
            default: ;  // reserved request keeps the present mode
         endcase
      end

      // Any switch into heat or cool rearms the delay.
      if (output_mode_in != output_mode_ff && output_mode_in != MODE_OFF) begin
         fan_delay_end_in = in_now_ff + TimeWidth'(fan_delay_ms_ff);
      end else begin
         fan_delay_end_in = fan_delay_end_ff;
      end

      equip_on   = output_mode_in != MODE_OFF;
      since_end  = in_now_ff - fan_delay_end_in;
      delay_done = !since_end[TimeWidth-1];

      // A stopped fan waits for the delay whenever the equipment is running, forced
      // or not; otherwise the fan runs whenever equipment or force asks.
      if (fan_running_ff || delay_done) begin
         fan_running_in = equip_on || force_fan_ff;
      end else begin
         fan_running_in = force_fan_ff && !equip_on;
      end

      out_in.drive_enable   = en;
      out_in.select_cool    = sel;
      out_in.fan_on         = fan_running_in;
      out_in.fan_forced_ind = force_fan_ff;
      out_in.fan_auto_ind   = !force_fan_ff;
      out_in.heat_req_ind   = mode_request_ff == MODE_HEAT;
      out_in.cool_req_ind   = mode_request_ff == MODE_COOL;
      out_in.led_off        = mode_request_ff == MODE_OFF;
      out_in.active_mode    = output_mode_in;
      out_in.report_changed = (output_mode_in != output_mode_ff) ||
                              (fan_running_in != fan_running_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         output_mode_ff   <= MODE_OFF;
         fan_running_ff   <= 1'b0;
         fan_delay_end_ff <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff     <= 1'b1;
            output_mode_ff   <= output_mode_in;
            fan_running_ff   <= fan_running_in;
            fan_delay_end_ff <= fan_delay_end_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_temp_ff <= req_temperature;
         in_now_ff  <= req_now_ms;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_drive_enable   = out_ff.drive_enable;
   assign rsp_select_cool    = out_ff.select_cool;
   assign rsp_fan_on         = out_ff.fan_on;
   assign rsp_fan_forced_ind = out_ff.fan_forced_ind;
   assign rsp_fan_auto_ind   = out_ff.fan_auto_ind;
   assign rsp_heat_req_ind   = out_ff.heat_req_ind;
   assign rsp_cool_req_ind   = out_ff.cool_req_ind;
   assign rsp_led_off        = out_ff.led_off;
   assign rsp_active_mode    = out_ff.active_mode;
   assign rsp_report_changed = out_ff.report_changed;

`ifndef NO_ASSERTIONS
   // A beat can only be refused when both stages are full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with a free stage");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_mode != 2'd3))
      else $error("reserved active mode reported");

   a_drive_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_enable) |->
         (rsp_active_mode == (rsp_select_cool ? MODE_COOL : MODE_HEAT)))
      else $error("drive enable disagrees with active mode");

   a_fan_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_active_mode == MODE_OFF && !rsp_fan_forced_ind) |-> !rsp_fan_on)
      else $error("fan running with equipment off and no force");

   a_state_moves: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(output_mode_ff) && $stable(fan_delay_end_ff))
      else $error("state changed without a beat");
`endif

endmodule
